/* rtl/tec_pkg.sv */
// Shared types and constants for the text encoding codec.
// No dependencies; imported by every module of the codec.
`default_nettype none

package tec_pkg;

    localparam int VALUE_W = 31;

    typedef enum logic [1:0] {
        ENC_ASCII = 2'd0,
        ENC_UTF8  = 2'd1,
        ENC_UCS2  = 2'd2
    } t_enc_kind;

    typedef enum logic {
        DIR_DECODE = 1'b0,
        DIR_ENCODE = 1'b1
    } t_dir;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_KIND = 2'd0;
    localparam logic [1:0] CFG_IDX_DIR  = 2'd1;

    typedef enum logic [1:0] {
        JOB_PLAIN = 2'd0,   // one result, value as is
        JOB_UCS2  = 2'd1,   // two bytes, low first
        JOB_UTF8  = 2'd2    // two to six bytes of a UTF-8 sequence
    } t_job_kind;

    typedef struct packed {
        logic [VALUE_W-1:0] in_value;
        logic               end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        logic               out_last;
        logic               out_error;
    } t_out_item;

    typedef struct packed {
        t_job_kind          kind;
        logic [2:0]         count;   // number of results, 1..6
        logic [VALUE_W-1:0] value;
        logic               error;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

    function automatic logic [7:0] utf8_lead(input logic [2:0] n);
        logic [7:0] lead;
        unique case (n)
            3'd2:    lead = 8'hc0;
            3'd3:    lead = 8'he0;
            3'd4:    lead = 8'hf0;
            3'd5:    lead = 8'hf8;
            3'd6:    lead = 8'hfc;
            default: lead = 8'h00;
        endcase
        return lead;
    endfunction

    // 6 * m for m in 0..5
    function automatic logic [4:0] six_times(input logic [2:0] m);
        logic [4:0] s;
        unique case (m)
            3'd0:    s = 5'd0;
            3'd1:    s = 5'd6;
            3'd2:    s = 5'd12;
            3'd3:    s = 5'd18;
            3'd4:    s = 5'd24;
            3'd5:    s = 5'd30;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/tec_front.sv */
// Front end: accepts items, runs the decode state and classifies encode work.
// Depends on tec_pkg; emits at most one job per accepted request.
`default_nettype none

module tec_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  tec_pkg::t_in_item  i_item,
    input  tec_pkg::t_enc_kind i_kind,
    input  tec_pkg::t_dir      i_dir,
    output logic               o_job_valid,
    output tec_pkg::t_job      o_job
);
    import tec_pkg::*;

    logic [2:0]         r_remaining, n_remaining;
    logic [VALUE_W-1:0] r_partial,   n_partial;
    logic [7:0]         r_low,       n_low;
    logic               r_low_valid, n_low_valid;
    logic               w_has_job;
    logic [7:0]         w_byte;
    logic               w_eos;
    logic [VALUE_W-1:0] w_cp;

    assign w_byte = i_item.in_value[7:0];
    assign w_eos  = i_item.end_of_source;
    assign w_cp   = i_item.in_value;

    always_comb begin
        n_remaining = r_remaining;
        n_partial   = r_partial;
        n_low       = r_low;
        n_low_valid = r_low_valid;
        w_has_job   = 1'b0;
        o_job.kind  = JOB_PLAIN;
        o_job.count = 3'd1;
        o_job.value = '0;
        o_job.error = 1'b0;

        if (i_dir == DIR_DECODE) begin
            unique case (i_kind)
                ENC_UTF8: begin
                    if (w_eos) begin
                        if (r_remaining != 3'd0) begin
                            n_remaining = 3'd0;
                            n_partial   = '0;
                            w_has_job   = 1'b1;
                            o_job.error = 1'b1;
                        end
                    end else if (r_remaining != 3'd0) begin
                        n_partial   = {r_partial[VALUE_W-7:0], w_byte[5:0]};
                        n_remaining = r_remaining - 3'd1;
                        if (n_remaining == 3'd0) begin
                            w_has_job   = 1'b1;
                            o_job.value = n_partial;
                            n_partial   = '0;
                        end
                    end else begin
                        priority if (w_byte < 8'h80) begin
                            w_has_job   = 1'b1;
                            o_job.value = {23'd0, w_byte};
                        end else if (w_byte < 8'hc0 || w_byte >= 8'hfe) begin
                            // stray continuation or never-valid lead
                            w_has_job   = 1'b1;
                            o_job.value = {23'd0, w_byte};
                            o_job.error = 1'b1;
                        end else if (w_byte < 8'he0) begin
                            n_remaining = 3'd1;
                            n_partial   = {26'd0, w_byte[4:0]};
                        end else if (w_byte < 8'hf0) begin
                            n_remaining = 3'd2;
                            n_partial   = {27'd0, w_byte[3:0]};
                        end else if (w_byte < 8'hf8) begin
                            n_remaining = 3'd3;
                            n_partial   = {28'd0, w_byte[2:0]};
                        end else if (w_byte < 8'hfc) begin
                            n_remaining = 3'd4;
                            n_partial   = {29'd0, w_byte[1:0]};
                        end else begin
                            n_remaining = 3'd5;
                            n_partial   = {30'd0, w_byte[0]};
                        end
                    end
                end
                ENC_UCS2: begin
                    if (w_eos) begin
                        if (r_low_valid) begin
                            n_low_valid = 1'b0;
                            n_low       = '0;
                            w_has_job   = 1'b1;
                            o_job.error = 1'b1;
                        end
                    end else if (!r_low_valid) begin
                        n_low       = w_byte;
                        n_low_valid = 1'b1;
                    end else begin
                        w_has_job   = 1'b1;
                        o_job.value = {15'd0, w_byte, r_low};
                        n_low_valid = 1'b0;
                        n_low       = '0;
                    end
                end
                default: begin
                    // ASCII, and the unused kind code
                    if (!w_eos) begin
                        w_has_job   = 1'b1;
                        o_job.value = {23'd0, w_byte};
                    end
                end
            endcase
        end else if (!w_eos) begin
            w_has_job   = 1'b1;
            o_job.value = w_cp;
            unique case (i_kind)
                ENC_UTF8: begin
                    priority if (w_cp < 31'h80) begin
                        o_job.kind = JOB_PLAIN;
                    end else if (w_cp < 31'h800) begin
                        o_job.kind  = JOB_UTF8;
                        o_job.count = 3'd2;
                    end else if (w_cp < 31'h10000) begin
                        o_job.kind  = JOB_UTF8;
                        o_job.count = 3'd3;
                    end else if (w_cp < 31'h200000) begin
                        o_job.kind  = JOB_UTF8;
                        o_job.count = 3'd4;
                    end else if (w_cp < 31'h4000000) begin
                        o_job.kind  = JOB_UTF8;
                        o_job.count = 3'd5;
                    end else begin
                        o_job.kind  = JOB_UTF8;
                        o_job.count = 3'd6;
                    end
                end
                ENC_UCS2: begin
                    o_job.kind  = JOB_UCS2;
                    o_job.count = 3'd2;
                end
                default: begin
                    o_job.value = {23'd0, w_cp[7:0]};
                end
            endcase
        end
    end

    assign o_job_valid = i_accept && w_has_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_partial   <= '0;
            r_low       <= '0;
            r_low_valid <= 1'b0;
        end else if (i_accept) begin
            r_remaining <= n_remaining;
            r_partial   <= n_partial;
            r_low       <= n_low;
            r_low_valid <= n_low_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/tec_job_fifo.sv */
// Short job queue between front and back end.
// Depends on tec_pkg; DEPTH must be a power of two, at least 2.
`default_nettype none

module tec_job_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_wr,
    input  tec_pkg::t_job         i_wr_job,
    input  wire                   i_rd,
    output tec_pkg::t_job         o_head,
    output tec_pkg::t_fifo_status o_status
);
    import tec_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/tec_back.sv */
// Back end: expands each job into result bytes or one code point, one a cycle
// while popped; depends on tec_pkg, owns the result register at the output.
`default_nettype none

module tec_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_job_avail,
    input  tec_pkg::t_job      i_job,
    output logic               o_job_done,
    input  wire                i_pop,
    output logic               o_out_valid,
    output tec_pkg::t_out_item o_out
);
    import tec_pkg::*;

    logic [2:0]         r_idx;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               w_load;
    logic               w_last;
    logic [2:0]         w_left;
    logic [VALUE_W-1:0] w_shifted;
    t_out_item          n_out;

    assign w_load    = i_job_avail && (!r_out_valid || i_pop);
    assign w_last    = (r_idx == i_job.count - 3'd1);
    assign w_left    = i_job.count - 3'd1 - r_idx;
    assign w_shifted = i_job.value >> six_times(w_left);

    always_comb begin
        n_out.out_last  = w_last;
        n_out.out_error = i_job.error;
        unique case (i_job.kind)
            JOB_UTF8: begin
                if (r_idx == 3'd0) begin
                    n_out.out_value = {23'd0, utf8_lead(i_job.count) | w_shifted[7:0]};
                end else begin
                    n_out.out_value = {23'd0, 2'b10, w_shifted[5:0]};
                end
            end
            JOB_UCS2: begin
                n_out.out_value = (r_idx == 3'd0) ? {23'd0, i_job.value[7:0]}
                                                  : {23'd0, i_job.value[15:8]};
            end
            default: begin
                n_out.out_value = i_job.value;
            end
        endcase
    end

    assign o_job_done  = w_load && w_last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= w_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/text_encoding_codec.sv */
// Text encoding codec: ASCII, 31-bit UTF-8 and UCS-2 LE, decode and encode.
// Path: each job is registered in the job queue, then in the result register.
// Throughput: one item per cycle while the job queue has room; a job yielding n
//   results holds the back end for one result register load per result, so a
//   wide UTF-8 encode yields up to six results and the job queue absorbs the burst.
// Reset: synchronous, active low; clears decode state, queue and result flag.
`default_nettype none

module text_encoding_codec #(
    parameter int QUEUE_DEPTH = 4   // job queue entries, power of two
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // input queue side
    input  wire                push,
    output logic               full,
    input  tec_pkg::t_in_item  i_item,
    // result queue side
    output logic               empty,
    input  wire                pop,
    output tec_pkg::t_out_item o_result,
    // configuration writes
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [1:0]          i_cfg_index,
    input  wire [1:0]          i_cfg_data
);
    import tec_pkg::*;

    t_enc_kind    r_kind;
    t_dir         r_dir;
    logic         w_accept;
    logic         w_job_push;
    t_job         w_job;
    t_job         w_head;
    t_fifo_status w_fifo_stat;
    logic         w_job_done;
    logic         w_out_valid;

    // Config writes are always taken; the user must issue them only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= ENC_UTF8;
            r_dir  <= DIR_DECODE;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_KIND) begin
                r_kind <= t_enc_kind'(i_cfg_data);
            end else if (i_cfg_index == CFG_IDX_DIR) begin
                r_dir <= t_dir'(i_cfg_data[0]);
            end
        end
    end

    // A request is taken whenever the job queue has room, even when it
    // produces no job (lead bytes, first UCS-2 byte, idle end of source).
    assign full     = w_fifo_stat.full;
    assign w_accept = push && !full;

    tec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_kind      (r_kind),
        .i_dir       (r_dir),
        .o_job_valid (w_job_push),
        .o_job       (w_job)
    );

    tec_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_job_push),
        .i_wr_job (w_job),
        .i_rd     (w_job_done),
        .o_head   (w_head),
        .o_status (w_fifo_stat)
    );

    // Back end retires a job on its last result; a new result loads in the cycle
    // the waiting one is popped, so steady pops with jobs queued give one per cycle.
    // While a result waits unpopped, jobs back up in the queue.
    tec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!w_fifo_stat.empty),
        .i_job       (w_head),
        .o_job_done  (w_job_done),
        .i_pop       (pop),
        .o_out_valid (w_out_valid),
        .o_out       (o_result)
    );

    assign empty = !w_out_valid;

    // Queue flags never both set.
    a_fifo_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fifo_stat.full && w_fifo_stat.empty))
        else $error("job queue full and empty together");

    // Front only writes into a queue with room.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_push |-> !w_fifo_stat.full)
        else $error("job written into full queue");

    // A job retires only when one is present.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_done |-> !w_fifo_stat.empty)
        else $error("job retired from empty queue");

    // Errors are always single, final results.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_error) |-> o_result.out_last)
        else $error("error result without last flag");

endmodule

`default_nettype wire
